>>> hw/rtl/mcmb_pkg.sv
// Package with shared types and constants for the channel mailbox.
package mcmb_pkg;
	localparam int MaxChannels = 8;
	localparam int RingDepth = 16;
	localparam int WordBits = 32;
	localparam int ChW = $clog2(MaxChannels);
	localparam int PosW = $clog2(RingDepth);
	localparam int LimW = $clog2(RingDepth + 1);
	localparam int AddrW = ChW + PosW;

	typedef enum logic [2:0] {
		ACT_OPEN = 3'd0,
		ACT_CLOSE = 3'd1,
		ACT_SEND = 3'd2,
		ACT_RECV = 3'd3,
		ACT_BCAST = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_CHANNEL = 2'd1,
		ST_WOULD_BLOCK = 2'd2,
		ST_NO_SLOT = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] channel_index;
		logic [4:0] open_limit;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] read_data;
		logic [2:0] opened_index;
	} rsp_t;

	typedef struct packed {
		logic [LimW-1:0] limit;
		logic [PosW-1:0] head;
		logic [PosW-1:0] tail;
		logic [LimW-1:0] fill;
	} slot_t;

	typedef struct packed {
		logic we;
		logic [AddrW-1:0] waddr;
		logic [WordBits-1:0] wdata;
		logic re;
		logic [AddrW-1:0] raddr;
	} word_cmd_t;
endpackage

>>> hw/rtl/mcmb_if.sv
// Valid and ready channel interface carrying one payload.
interface mcmb_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/mcmb_word_ram.sv
// Word store of all channel rings, one write and one registered read port.
module mcmb_word_ram (
	input logic clk,
	input mcmb_pkg::word_cmd_t cmd,
	output logic [mcmb_pkg::WordBits-1:0] rdata
);
	import mcmb_pkg::*;
	logic [WordBits-1:0] mem [MaxChannels*RingDepth];
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rdata <= mem[cmd.raddr];
		end
	end
endmodule

>>> hw/rtl/mcmb_ctrl.sv
// Sequencer that walks slot descriptors and drives the word store.
module mcmb_ctrl (
	input logic clk,
	input logic arst_n,
	mcmb_if.sink req,
	mcmb_if.source rsp,
	output mcmb_pkg::word_cmd_t cmd,
	input logic [mcmb_pkg::WordBits-1:0] ram_rdata
);
	import mcmb_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_PUSH = 5'b00100,
		S_READ = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	req_t req_q;
	slot_t slot_q [MaxChannels];
	logic [MaxChannels-1:0] open_q;
	logic [ChW:0] walk_q;
	logic any_q;
	logic full_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [ChW-1:0] ch;
	logic [ChW-1:0] wch;
	logic [PosW-1:0] nxt_tail;
	logic [PosW-1:0] nxt_head;
	logic [LimW-1:0] sat_lim;
	logic [ChW-1:0] free_idx;
	logic free_any;
	logic ch_ok;

	assign ch = req_q.channel_index[ChW-1:0];
	assign wch = walk_q[ChW-1:0];
	assign sat_lim = (req_q.open_limit > 5'(RingDepth)) ? LimW'(RingDepth)
		: LimW'(req_q.open_limit);
	assign ch_ok = ((ChW+1)'(req_q.channel_index) < (ChW+1)'(MaxChannels)) && open_q[ch];

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MaxChannels - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				free_any = 1'b1;
				free_idx = ChW'(i);
			end
		end
	end

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	logic [ChW-1:0] pch;
	assign pch = (req_q.action == ACT_BCAST) ? wch : ch;
	assign nxt_tail = (LimW'(slot_q[pch].tail) + 1'b1 >= slot_q[pch].limit) ? '0
		: slot_q[pch].tail + 1'b1;
	assign nxt_head = (LimW'(slot_q[ch].head) + 1'b1 >= slot_q[ch].limit) ? '0
		: slot_q[ch].head + 1'b1;

	always_comb begin
		cmd = '0;
		cmd.wdata = req_q.write_data[WordBits-1:0];
		cmd.waddr = {pch, slot_q[pch].tail};
		cmd.raddr = {ch, slot_q[ch].head};
		if (state_q == S_PUSH) begin
			cmd.we = (req_q.action == ACT_SEND) || open_q[wch];
		end
		cmd.re = (state_q == S_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= '0;
			rsp_valid_q <= 1'b0;
			walk_q <= '0;
			any_q <= 1'b0;
			full_q <= 1'b0;
			for (int i = 0; i < MaxChannels; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						walk_q <= '0;
						any_q <= 1'b0;
						full_q <= 1'b0;
						rsp_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_DONE;
					case (req_q.action)
						ACT_OPEN: begin
							if (free_any) begin
								open_q[free_idx] <= 1'b1;
								slot_q[free_idx] <= '{limit: sat_lim, head: '0,
									tail: '0, fill: '0};
								rsp_q.opened_index <= 3'(free_idx);
								rsp_q.status <= ST_OK;
							end else begin
								rsp_q.status <= ST_NO_SLOT;
							end
						end
						ACT_CLOSE: begin
							if (ch_ok) begin
								open_q[ch] <= 1'b0;
								slot_q[ch] <= '0;
								rsp_q.status <= ST_OK;
							end else begin
								rsp_q.status <= ST_NO_CHANNEL;
							end
						end
						ACT_SEND: begin
							if (!ch_ok) begin
								rsp_q.status <= ST_NO_CHANNEL;
							end else if (slot_q[ch].fill < slot_q[ch].limit) begin
								rsp_q.status <= ST_OK;
								state_q <= S_PUSH;
							end else begin
								rsp_q.status <= ST_WOULD_BLOCK;
							end
						end
						ACT_RECV: begin
							if (!ch_ok) begin
								rsp_q.status <= ST_NO_CHANNEL;
							end else if (slot_q[ch].fill != '0) begin
								rsp_q.status <= ST_OK;
								state_q <= S_READ;
							end else begin
								rsp_q.status <= ST_WOULD_BLOCK;
							end
						end
						ACT_BCAST: begin
							if (walk_q == (ChW+1)'(MaxChannels)) begin
								walk_q <= '0;
								if (full_q) begin
									rsp_q.status <= ST_WOULD_BLOCK;
								end else if (!any_q) begin
									rsp_q.status <= ST_NO_CHANNEL;
								end else begin
									rsp_q.status <= ST_OK;
									state_q <= S_PUSH;
								end
							end else begin
								state_q <= S_SCAN;
								walk_q <= walk_q + 1'b1;
								if (open_q[wch]) begin
									any_q <= 1'b1;
									if (slot_q[wch].fill >= slot_q[wch].limit) begin
										full_q <= 1'b1;
									end
								end
							end
						end
						default: rsp_q.status <= ST_NO_CHANNEL;
					endcase
				end
				S_PUSH: begin
					if (cmd.we) begin
						slot_q[pch].tail <= nxt_tail;
						slot_q[pch].fill <= slot_q[pch].fill + 1'b1;
					end
					if (req_q.action == ACT_BCAST && walk_q != (ChW+1)'(MaxChannels - 1)) begin
						walk_q <= walk_q + 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					slot_q[ch].head <= nxt_head;
					slot_q[ch].fill <= slot_q[ch].fill - 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (req_q.action == ACT_RECV && rsp_q.status == ST_OK) begin
						rsp_q.read_data <= 32'(ram_rdata);
					end
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/multi_channel_mailbox_fifo_top.sv
// Top level of the multi-channel bounded FIFO mailbox.
// Open, close and rejected requests pass through scan and done; send adds a push state,
// receive adds a read state, and broadcast walks every slot descriptor once to check and
// once to push through the single word store write port.
// One request is in flight at a time; the next is taken once the response is taken.
// Reset closes all channels at once; the word store is not cleared.
module multi_channel_mailbox_fifo_top (
	input logic clk,
	input logic arst_n,
	mcmb_if.sink req,
	mcmb_if.source rsp
);
	import mcmb_pkg::*;
	word_cmd_t cmd;
	logic [WordBits-1:0] ram_rdata;

	mcmb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cmd(cmd), .ram_rdata(ram_rdata)
	);
	mcmb_word_ram u_ram (.clk(clk), .cmd(cmd), .rdata(ram_rdata));

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("request taken while response pending");
	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.we |-> !cmd.re) else $error("word store read and write together");
	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !rsp.valid) else $error("response too early");
endmodule

>>> tb/multi_channel_mailbox_fifo_top_tb.sv
// Testbench for the channel mailbox: directed table, random requests, predicted responses.
`timescale 1ns / 100ps
module multi_channel_mailbox_fifo_top_tb;
	import mcmb_pkg::*;

	localparam int LimitCycles = 400000;
	localparam int DirCount = 24;

	logic clk;
	logic arst_n;
	mcmb_if #(.payload_t(req_t)) req_ch (.clk(clk));
	mcmb_if #(.payload_t(rsp_t)) rsp_ch (.clk(clk));

	multi_channel_mailbox_fifo_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	typedef struct {
		req_t r;
		logic has_rsp;
		rsp_t x;
	} dir_row_t;

	bit mb_open [MaxChannels];
	int mb_limit [MaxChannels];
	int mb_head [MaxChannels];
	int mb_tail [MaxChannels];
	int mb_fill [MaxChannels];
	logic [31:0] mb_words [MaxChannels][RingDepth];
	rsp_t pending_rsp [$];
	dir_row_t dir_rows [DirCount];
	int errors = 0;
	int cycles = 0;
	int accepted = 0;
	int responses = 0;
	bit quiet = 0;
	bit hold_rsp = 0;

	function automatic req_t mk(action_t a, int ch, int lim, logic [31:0] w);
		req_t r;
		r.action = a;
		r.channel_index = ch[2:0];
		r.open_limit = lim[4:0];
		r.write_data = w;
		return r;
	endfunction

	function automatic rsp_t mkr(status_t s, logic [31:0] d, int o);
		rsp_t x;
		x.status = s;
		x.read_data = d;
		x.opened_index = o[2:0];
		return x;
	endfunction

	function automatic void mailbox_push(int s, logic [31:0] w);
		mb_words[s][mb_tail[s]] = w;
		mb_tail[s] = (mb_tail[s] + 1 >= mb_limit[s]) ? 0 : mb_tail[s] + 1;
		mb_fill[s]++;
	endfunction

	function automatic rsp_t mailbox_apply(req_t r);
		rsp_t x;
		int s;
		bit ok_ch;
		bit full;
		int cnt;
		x = mkr(ST_NO_CHANNEL, 32'd0, 0);
		s = r.channel_index;
		ok_ch = mb_open[s];
		case (r.action)
			ACT_OPEN: begin
				x.status = ST_NO_SLOT;
				for (int i = 0; i < MaxChannels; i++) begin
					if (!mb_open[i]) begin
						mb_open[i] = 1;
						mb_limit[i] = (r.open_limit > RingDepth) ? RingDepth : r.open_limit;
						mb_head[i] = 0;
						mb_tail[i] = 0;
						mb_fill[i] = 0;
						x.opened_index = i[2:0];
						x.status = ST_OK;
						break;
					end
				end
			end
			ACT_CLOSE: begin
				if (ok_ch) begin
					mb_open[s] = 0;
					mb_limit[s] = 0;
					mb_fill[s] = 0;
					x.status = ST_OK;
				end
			end
			ACT_SEND: begin
				if (ok_ch) begin
					if (mb_fill[s] < mb_limit[s]) begin
						mailbox_push(s, r.write_data);
						x.status = ST_OK;
					end else begin
						x.status = ST_WOULD_BLOCK;
					end
				end
			end
			ACT_RECV: begin
				if (ok_ch) begin
					if (mb_fill[s] > 0) begin
						x.read_data = mb_words[s][mb_head[s]];
						mb_head[s] = (mb_head[s] + 1 >= mb_limit[s]) ? 0 : mb_head[s] + 1;
						mb_fill[s]--;
						x.status = ST_OK;
					end else begin
						x.status = ST_WOULD_BLOCK;
					end
				end
			end
			ACT_BCAST: begin
				cnt = 0;
				full = 0;
				for (int i = 0; i < MaxChannels; i++) begin
					if (mb_open[i]) begin
						cnt++;
						if (mb_fill[i] >= mb_limit[i]) full = 1;
					end
				end
				if (full) begin
					x.status = ST_WOULD_BLOCK;
				end else if (cnt > 0) begin
					for (int i = 0; i < MaxChannels; i++)
						if (mb_open[i]) mailbox_push(i, r.write_data);
					x.status = ST_OK;
				end
			end
			default: x.status = ST_NO_CHANNEL;
		endcase
		return x;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LimitCycles) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			responses++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %p", $realtime, rsp_ch.data);
				errors++;
			end else begin
				rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp_ch.data.status !== e.status)
					$display("%0t: status expected %0d actual %0d", $realtime,
						e.status, rsp_ch.data.status);
				if (rsp_ch.data.read_data !== e.read_data)
					$display("%0t: read_data expected %h actual %h", $realtime,
						e.read_data, rsp_ch.data.read_data);
				if (rsp_ch.data.opened_index !== e.opened_index)
					$display("%0t: opened_index expected %0d actual %0d", $realtime,
						e.opened_index, rsp_ch.data.opened_index);
				if (rsp_ch.data !== e) errors++;
			end
		end
	end

	initial begin
		rsp_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 0;
				repeat (300) @(posedge clk);
				hold_rsp = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 0;
				repeat ($urandom_range(1, 16) - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1;
			end
		end
	end

	task automatic send_request(req_t r);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		accepted++;
	endtask

	task automatic drain;
		req_ch.valid <= 0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic req_t random_request(int bias);
		req_t r;
		int a;
		a = $urandom_range(0, 99);
		if (a < 8) r.action = ACT_OPEN;
		else if (a < 14) r.action = ACT_CLOSE;
		else if (a < 14 + bias) r.action = ACT_SEND;
		else if (a < 93) r.action = ACT_RECV;
		else if (a < 98) r.action = ACT_BCAST;
		else r.action = 3'($urandom_range(5, 7));
		r.channel_index = 3'($urandom_range(0, 7));
		r.open_limit = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
		r.write_data = $urandom;
		return r;
	endfunction

	initial begin
		rsp_t got;
		req_t r;
		req_ch.valid = 0;
		req_ch.data = '0;
		for (int i = 0; i < MaxChannels; i++) begin
			mb_open[i] = 0;
			mb_limit[i] = 0;
			mb_fill[i] = 0;
		end
		dir_rows[0] = '{mk(ACT_RECV, 0, 0, 0), 1, mkr(ST_NO_CHANNEL, 0, 0)};
		dir_rows[1] = '{mk(ACT_BCAST, 0, 0, 32'h1), 1, mkr(ST_NO_CHANNEL, 0, 0)};
		dir_rows[2] = '{mk(ACT_CLOSE, 7, 0, 0), 1, mkr(ST_NO_CHANNEL, 0, 0)};
		dir_rows[3] = '{mk(ACT_OPEN, 0, 31, 0), 1, mkr(ST_OK, 0, 0)};
		dir_rows[4] = '{mk(ACT_OPEN, 5, 0, 0), 1, mkr(ST_OK, 0, 1)};
		dir_rows[5] = '{mk(ACT_SEND, 1, 0, 32'hFFFFFFFF), 1, mkr(ST_WOULD_BLOCK, 0, 0)};
		dir_rows[6] = '{mk(ACT_RECV, 1, 0, 0), 1, mkr(ST_WOULD_BLOCK, 0, 0)};
		dir_rows[7] = '{mk(ACT_BCAST, 0, 0, 32'h5), 1, mkr(ST_WOULD_BLOCK, 0, 0)};
		dir_rows[8] = '{mk(ACT_SEND, 0, 0, 32'hFFFFFFFF), 1, mkr(ST_OK, 0, 0)};
		dir_rows[9] = '{mk(ACT_SEND, 0, 0, 32'h0), 0, '0};
		dir_rows[10] = '{mk(ACT_RECV, 0, 0, 0), 1, mkr(ST_OK, 32'hFFFFFFFF, 0)};
		dir_rows[11] = '{mk(ACT_CLOSE, 1, 0, 0), 1, mkr(ST_OK, 0, 0)};
		dir_rows[12] = '{mk(ACT_OPEN, 0, 1, 0), 1, mkr(ST_OK, 0, 1)};
		dir_rows[13] = '{mk(ACT_BCAST, 0, 0, 32'hA5A5A5A5), 1, mkr(ST_OK, 0, 0)};
		dir_rows[14] = '{mk(ACT_BCAST, 0, 0, 32'h1), 1, mkr(ST_WOULD_BLOCK, 0, 0)};
		dir_rows[15] = '{mk(ACT_RECV, 1, 0, 0), 1, mkr(ST_OK, 32'hA5A5A5A5, 0)};
		dir_rows[16] = '{mk(ACT_RECV, 0, 0, 0), 0, '0};
		dir_rows[17] = '{mk(action_t'(3'd5), 0, 0, 0), 1, mkr(ST_NO_CHANNEL, 0, 0)};
		dir_rows[18] = '{mk(action_t'(3'd7), 7, 31, 32'hFFFFFFFF), 1, mkr(ST_NO_CHANNEL, 0, 0)};
		for (int i = 19; i < DirCount; i++)
			dir_rows[i] = '{mk(ACT_OPEN, 0, 16, 0), 0, '0};
		@(posedge arst_n);
		@(posedge clk);
		foreach (dir_rows[i]) begin
			got = mailbox_apply(dir_rows[i].r);
			pending_rsp.push_back(dir_rows[i].has_rsp ? dir_rows[i].x : got);
			send_request(dir_rows[i].r);
		end
		// The first open takes the last free slot, and the second has nowhere to go.
		for (int i = 0; i < 2; i++) begin
			r = mk(ACT_OPEN, 0, 4, 0);
			pending_rsp.push_back(i == 0 ? mailbox_apply(r) : mailbox_apply(r));
			send_request(r);
		end
		drain();
		for (int n = 0; n < 1850; n++) begin
			if (n == 300) hold_rsp = 1;
			if (n == 900) drain();
			if (n >= 1650) quiet = 1;
			r = random_request(n % 400 < 200 ? 50 : 25);
			pending_rsp.push_back(mailbox_apply(r));
			send_request(r);
		end
		req_ch.valid <= 0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("%0d requests sent and %0d responses checked.", accepted, responses);
		$display("Covered open, close, send, receive, broadcast, unknown actions and stalls.");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

>>> files.f
hw/rtl/mcmb_pkg.sv
hw/rtl/mcmb_if.sv
hw/rtl/mcmb_word_ram.sv
hw/rtl/mcmb_ctrl.sv
hw/rtl/multi_channel_mailbox_fifo_top.sv
tb/multi_channel_mailbox_fifo_top_tb.sv
